// ----- rtl/p2fla_pkg.sv -----
package p2fla_pkg;

  localparam int AddrBits     = 16;
  localparam int CarveLog2    = 13;
  localparam int MinClassLog2 = 3;
  localparam int HeaderBytes  = 8;

  localparam int SIZE_W      = AddrBits + 1;
  localparam int HEAP_W      = AddrBits + 1;
  localparam int LINK_W      = AddrBits + 1;
  localparam int SUM_W       = AddrBits + 2;
  localparam int SLOT_W      = AddrBits - 3;
  localparam int SLOT_COUNT  = 2 ** SLOT_W;
  localparam int CLASS_W     = 5;
  localparam int CLASS_COUNT = AddrBits - MinClassLog2 + 1;
  localparam int IDX_W       = $clog2(CLASS_COUNT);
  localparam int CNT_W       = CarveLog2 - MinClassLog2 + 1;
  localparam int HEAP_BASE   = 8;
  localparam int HEAP_END_RESET = 2 ** AddrBits;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OLD,
    S_ALLOC,
    S_POP,
    S_CARVE,
    S_AFTER,
    S_PUSH_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_class;
    logic rd_next;
    logic pop;
    logic carve_start;
    logic carve_step;
    logic push;
    logic set_ptr;
    logic set_err;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ptr_null;
    logic req_zero;
    logic class_over;
    logic head_valid;
    logic carve_fail;
    logic multi;
    logic last;
    logic old_valid;
    logic old_fits;
  } sts_t;

  // Smallest class c >= MinClassLog2 with 2^c >= size (size nonzero).
  function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0]  m;
    logic [CLASS_W-1:0] c;
    m = size - SIZE_W'(1);
    c = CLASS_W'(MinClassLog2);
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i] && (CLASS_W'(i + 1) > c)) c = CLASS_W'(i + 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/p2fla_if.sv -----
interface p2fla_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic [p2fla_pkg::SIZE_W-1:0]     request_bytes;
  logic [p2fla_pkg::AddrBits-1:0]   block_address;
  modport source (output valid, operation, request_bytes, block_address, input ready);
  modport sink (input valid, operation, request_bytes, block_address, output ready);
endinterface

interface p2fla_out_if;
  logic                             valid;
  logic                             ready;
  logic [p2fla_pkg::AddrBits-1:0]   result_address;
  logic                             status;
  logic [15:0]                      copy_bytes;
  modport source (output valid, result_address, status, copy_bytes, input ready);
  modport sink (input valid, result_address, status, copy_bytes, output ready);
endinterface

interface p2fla_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [p2fla_pkg::HEAP_W-1:0]     heap_end;
  modport source (output valid, heap_end, input ready);
  modport sink (input valid, heap_end, output ready);
endinterface

// ----- rtl/p2fla_ctrl.sv -----
module p2fla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  p2fla_pkg::sts_t   sts,
  output p2fla_pkg::cmd_t   cmd
);

  p2fla_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              mov;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= p2fla_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A moving reallocate must hand the old block back after a good allocate.
  assign mov = (sts.op == p2fla_pkg::OP_REALLOC) && !sts.ptr_null;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      p2fla_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = p2fla_pkg::S_DECODE;
        end
      end
      p2fla_pkg::S_DECODE: begin
        unique case (sts.op)
          p2fla_pkg::OP_ALLOC: state_nxt = p2fla_pkg::S_ALLOC;
          p2fla_pkg::OP_NONE:  state_nxt = p2fla_pkg::S_AFTER;
          default: begin
            if (sts.ptr_null) begin
              state_nxt = (sts.op == p2fla_pkg::OP_REALLOC) ? p2fla_pkg::S_ALLOC
                                                            : p2fla_pkg::S_AFTER;
            end else begin
              cmd.rd_class = 1'b1;
              state_nxt    = p2fla_pkg::S_OLD;
            end
          end
        endcase
      end
      p2fla_pkg::S_OLD: begin
        if (sts.op == p2fla_pkg::OP_FREE || sts.req_zero) begin
          state_nxt = sts.old_valid ? p2fla_pkg::S_PUSH_DONE : p2fla_pkg::S_AFTER;
        end else if (sts.old_valid && sts.old_fits) begin
          cmd.set_ptr = 1'b1;
          state_nxt   = p2fla_pkg::S_AFTER;
        end else begin
          state_nxt = p2fla_pkg::S_ALLOC;
        end
      end
      p2fla_pkg::S_ALLOC: begin
        if (sts.req_zero) begin
          state_nxt = p2fla_pkg::S_AFTER;
        end else if (sts.class_over) begin
          cmd.set_err = 1'b1;
          state_nxt   = p2fla_pkg::S_AFTER;
        end else if (sts.head_valid) begin
          cmd.rd_next = 1'b1;
          state_nxt   = p2fla_pkg::S_POP;
        end else if (sts.carve_fail) begin
          cmd.set_err = 1'b1;
          state_nxt   = p2fla_pkg::S_AFTER;
        end else begin
          cmd.carve_start = 1'b1;
          state_nxt = sts.multi ? p2fla_pkg::S_CARVE : p2fla_pkg::S_PUSH_DONE;
          if (!sts.multi && !(mov && sts.old_valid)) state_nxt = p2fla_pkg::S_AFTER;
        end
      end
      p2fla_pkg::S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = (mov && sts.old_valid) ? p2fla_pkg::S_PUSH_DONE : p2fla_pkg::S_AFTER;
      end
      p2fla_pkg::S_CARVE: begin
        cmd.carve_step = 1'b1;
        if (sts.last) begin
          state_nxt = (mov && sts.old_valid) ? p2fla_pkg::S_PUSH_DONE : p2fla_pkg::S_AFTER;
        end
      end
      p2fla_pkg::S_PUSH_DONE: begin
        cmd.push  = 1'b1;
        state_nxt = p2fla_pkg::S_AFTER;
      end
      p2fla_pkg::S_AFTER: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = p2fla_pkg::S_IDLE;
        end
      end
      default: state_nxt = p2fla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/p2fla_dp.sv -----
module p2fla_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [1:0]                       in_operation,
  input  logic [p2fla_pkg::SIZE_W-1:0]     in_request_bytes,
  input  logic [p2fla_pkg::AddrBits-1:0]   in_block_address,
  input  logic                             cfg_we,
  input  logic [p2fla_pkg::HEAP_W-1:0]     cfg_heap_end,
  input  p2fla_pkg::cmd_t                  cmd,
  output p2fla_pkg::sts_t                  sts,
  output logic [p2fla_pkg::AddrBits-1:0]   out_result_address,
  output logic                             out_status,
  output logic [15:0]                      out_copy_bytes
);

  localparam int AW = p2fla_pkg::AddrBits;

  // Item registers.
  p2fla_pkg::op_t                  op_r;
  logic [p2fla_pkg::SIZE_W-1:0]    req_r;
  logic [AW-1:0]                   ptr_r;
  logic [p2fla_pkg::CLASS_W-1:0]   cls_r;
  logic                            req_zero_r;
  logic [AW-1:0]                   res_r;
  logic                            err_r;
  logic [15:0]                     copy_r;
  logic [AW-1:0]                   out_res_r;
  logic                            out_err_r;
  logic [15:0]                     out_copy_r;

  // Allocator state.
  logic [p2fla_pkg::LINK_W-1:0]    heads_r [p2fla_pkg::CLASS_COUNT];
  logic [p2fla_pkg::HEAP_W-1:0]    bump_r;
  logic [p2fla_pkg::HEAP_W-1:0]    heap_end_r;
  logic [AW-1:0]                   it_r;
  logic [p2fla_pkg::CNT_W-1:0]     cnt_r;

  logic [p2fla_pkg::CLASS_W-1:0]   cls_mem  [p2fla_pkg::SLOT_COUNT];
  logic [p2fla_pkg::LINK_W-1:0]    next_mem [p2fla_pkg::SLOT_COUNT];
  logic [p2fla_pkg::CLASS_W-1:0]   cls_rd_r;
  logic [p2fla_pkg::LINK_W-1:0]    next_rd_r;

  logic [AW-1:0]                   item_old;
  logic [p2fla_pkg::SLOT_W-1:0]    slot_old;
  logic [p2fla_pkg::IDX_W-1:0]     idx_req, idx_old, hidx;
  logic [p2fla_pkg::LINK_W-1:0]    head_q;
  logic [p2fla_pkg::SUM_W-1:0]     item_size, total, carve_end, first_next, it_next;
  logic                            small_cls;
  logic [p2fla_pkg::CLASS_W-1:0]   sh;
  logic [p2fla_pkg::CNT_W-1:0]     count_m1;
  logic [p2fla_pkg::HEAP_W-1:0]    limit;
  logic [p2fla_pkg::CLASS_W-1:0]   cls_wdata;
  logic [p2fla_pkg::SLOT_W-1:0]    cls_waddr, next_waddr;
  logic [p2fla_pkg::LINK_W-1:0]    next_wdata;
  logic [p2fla_pkg::CLASS_W-1:0]   idx_req_w, idx_old_w;

  assign item_old  = ptr_r - AW'(p2fla_pkg::HeaderBytes);
  assign slot_old  = item_old[AW-1:3];
  assign idx_req_w = cls_r - p2fla_pkg::CLASS_W'(p2fla_pkg::MinClassLog2);
  assign idx_old_w = cls_rd_r - p2fla_pkg::CLASS_W'(p2fla_pkg::MinClassLog2);
  assign idx_req   = idx_req_w[p2fla_pkg::IDX_W-1:0];
  assign idx_old   = idx_old_w[p2fla_pkg::IDX_W-1:0];
  assign hidx      = cmd.push ? idx_old : idx_req;
  assign head_q    = heads_r[hidx];

  // Carve geometry: a small class carves a run worth 2^CarveLog2 payload bytes.
  assign item_size = p2fla_pkg::SUM_W'(p2fla_pkg::HeaderBytes)
                   + (p2fla_pkg::SUM_W'(1) << cls_r);
  assign small_cls = cls_r < p2fla_pkg::CLASS_W'(p2fla_pkg::CarveLog2);
  assign sh        = p2fla_pkg::CLASS_W'(p2fla_pkg::CarveLog2) - cls_r;
  assign count_m1  = small_cls ? ((p2fla_pkg::CNT_W'(1) << sh) - p2fla_pkg::CNT_W'(1))
                               : '0;
  assign total     = small_cls ? ((p2fla_pkg::SUM_W'(1) << p2fla_pkg::CarveLog2)
                                 + (p2fla_pkg::SUM_W'(p2fla_pkg::HeaderBytes) << sh))
                               : item_size;
  assign limit     = (heap_end_r > p2fla_pkg::HEAP_W'(p2fla_pkg::HEAP_END_RESET))
                   ? p2fla_pkg::HEAP_W'(p2fla_pkg::HEAP_END_RESET) : heap_end_r;
  assign carve_end = p2fla_pkg::SUM_W'(bump_r) + total;
  assign first_next = p2fla_pkg::SUM_W'(bump_r) + item_size;
  assign it_next   = p2fla_pkg::SUM_W'(it_r) + item_size;

  always_comb begin
    sts.op         = op_r;
    sts.ptr_null   = ptr_r == '0;
    sts.req_zero   = req_zero_r;
    sts.class_over = cls_r > p2fla_pkg::CLASS_W'(AW);
    sts.head_valid = head_q[AW];
    sts.carve_fail = carve_end > p2fla_pkg::SUM_W'(limit);
    sts.multi      = small_cls;
    sts.last       = cnt_r == p2fla_pkg::CNT_W'(1);
    sts.old_valid  = (cls_rd_r >= p2fla_pkg::CLASS_W'(p2fla_pkg::MinClassLog2))
                  && (cls_rd_r <= p2fla_pkg::CLASS_W'(AW));
    sts.old_fits   = req_r <= (p2fla_pkg::SIZE_W'(1) << cls_rd_r);
  end

  // Memory write ports.
  assign cls_waddr  = cmd.carve_start ? bump_r[AW-1:3] : it_r[AW-1:3];
  assign cls_wdata  = cls_r;
  assign next_waddr = cmd.push ? slot_old : it_r[AW-1:3];
  assign next_wdata = cmd.push ? head_q
                    : (sts.last ? '0 : {1'b1, it_next[AW-1:0]});

  always_ff @(posedge clk) begin
    if (cmd.carve_start || cmd.carve_step) cls_mem[cls_waddr] <= cls_wdata;
    if (cmd.rd_class) cls_rd_r <= cls_mem[slot_old];
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.carve_step) next_mem[next_waddr] <= next_wdata;
    if (cmd.rd_next) next_rd_r <= next_mem[head_q[AW-1:3]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < p2fla_pkg::CLASS_COUNT; i++) heads_r[i] <= '0;
      bump_r     <= p2fla_pkg::HEAP_W'(p2fla_pkg::HEAP_BASE);
      heap_end_r <= p2fla_pkg::HEAP_W'(p2fla_pkg::HEAP_END_RESET);
    end else begin
      if (cfg_we) heap_end_r <= cfg_heap_end;
      if (cmd.pop) heads_r[idx_req] <= next_rd_r;
      if (cmd.carve_start) begin
        bump_r <= carve_end[p2fla_pkg::HEAP_W-1:0];
        if (small_cls) heads_r[idx_req] <= {1'b1, first_next[AW-1:0]};
      end
      if (cmd.push) heads_r[idx_old] <= {1'b1, item_old};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= p2fla_pkg::op_t'(in_operation);
      req_r      <= in_request_bytes;
      ptr_r      <= in_block_address;
      cls_r      <= p2fla_pkg::class_of(in_request_bytes);
      req_zero_r <= in_request_bytes == '0;
      res_r      <= '0;
      err_r      <= 1'b0;
      copy_r     <= '0;
    end
    if (cmd.pop) res_r <= head_q[AW-1:0] + AW'(p2fla_pkg::HeaderBytes);
    if (cmd.carve_start) begin
      res_r <= bump_r[AW-1:0] + AW'(p2fla_pkg::HeaderBytes);
      it_r  <= first_next[AW-1:0];
      cnt_r <= count_m1;
    end
    if (cmd.carve_step) begin
      it_r  <= it_next[AW-1:0];
      cnt_r <= cnt_r - p2fla_pkg::CNT_W'(1);
    end
    if (cmd.push && op_r == p2fla_pkg::OP_REALLOC && !req_zero_r) begin
      copy_r <= 16'((p2fla_pkg::SIZE_W'(1) << cls_rd_r));
    end
    if (cmd.set_ptr) res_r <= ptr_r;
    if (cmd.set_err) err_r <= 1'b1;
    if (cmd.emit) begin
      out_res_r  <= res_r;
      out_err_r  <= err_r;
      out_copy_r <= copy_r;
    end
  end

  assign out_result_address = out_res_r;
  assign out_status         = out_err_r;
  assign out_copy_bytes     = out_copy_r;

endmodule

// ----- rtl/pow2_free_list_allocator_core.sv -----
// The controller takes one item at a time: it accepts no new item until the last one
// is handed off into the output register. A small class refilled from the bump pointer
// adds a walk over its chained blocks, one at a time (up to 1023); a result that waits
// for the consumer holds the controller before the hand-off.
// Reset: free lists empty, bump pointer 8, heap_end 65536; no memory clearing pass.
module pow2_free_list_allocator_core (
  input logic          clk,
  input logic          rst_n,
  p2fla_in_if.sink     in_ch,
  p2fla_out_if.source  out_ch,
  p2fla_cfg_if.sink    cfg_ch
);

  p2fla_pkg::cmd_t cmd;
  p2fla_pkg::sts_t sts;

  // The heap_end register is always writable; software must only do so while idle.
  assign cfg_ch.ready = 1'b1;

  // The controller sequences one item at a time: decode, optional class lookup of
  // the old block, optional pop or carve, optional push of the old block, then
  // hand-off into the output register. The output register lets a new item start
  // while the previous result still waits for the consumer.
  p2fla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the list heads, bump pointer, link and class memories, and
  // the result registers.
  p2fla_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_ch.operation),
    .in_request_bytes   (in_ch.request_bytes),
    .in_block_address   (in_ch.block_address),
    .cfg_we             (cfg_ch.valid),
    .cfg_heap_end       (cfg_ch.heap_end),
    .cmd                (cmd),
    .sts                (sts),
    .out_result_address (out_ch.result_address),
    .out_status         (out_ch.status),
    .out_copy_bytes     (out_ch.copy_bytes)
  );

  // An error result never carries an address or a copy length.
  a_err_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.result_address == '0 && out_ch.copy_bytes == '0)
    else $error("error result carries data");

  // A copy length only comes with a moved block.
  a_copy_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.copy_bytes != '0 |-> out_ch.result_address != '0)
    else $error("copy length without new address");

  // Once an item is taken, no other is taken in the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while busy");

endmodule

// ----- tb/p2fla_checker.sv -----
`timescale 1ns / 100ps

module p2fla_checker
  import p2fla_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  p2fla_in_if   in_ch,
  p2fla_out_if  out_ch,
  p2fla_cfg_if  cfg_ch,
  output int    errors,
  output int    outstanding
);

  typedef struct {
    logic [AddrBits-1:0] addr;
    logic                status;
    logic [15:0]         copy;
  } reply_t;

  reply_t              replies_due[$];
  logic [LINK_W-1:0]   list_head[CLASS_COUNT];
  logic [LINK_W-1:0]   next_link[SLOT_COUNT];
  logic [CLASS_W-1:0]  stored_class[SLOT_COUNT];
  longint unsigned     bump;
  longint unsigned     heap_end;

  initial begin
    errors = 0;
    outstanding = 0;
    bump = HEAP_BASE;
    heap_end = HEAP_END_RESET;
    foreach (list_head[i]) list_head[i] = '0;
    foreach (next_link[i]) next_link[i] = '0;
    foreach (stored_class[i]) stored_class[i] = '0;
  end

  function automatic int slot_of(input longint unsigned item);
    return int'((item >> 3) & (SLOT_COUNT - 1));
  endfunction

  function automatic bit class_ok(input int c);
    return c >= MinClassLog2 && c <= AddrBits;
  endfunction

  task automatic push_block(input longint unsigned item, input int c);
    next_link[slot_of(item)] = list_head[c - MinClassLog2];
    list_head[c - MinClassLog2] = {1'b1, item[AddrBits-1:0]};
  endtask

  // Pops the class list or carves fresh heap from the bump pointer.
  task automatic take_block(input longint unsigned size, output logic [AddrBits-1:0] addr,
                            output logic err);
    int c;
    int idx;
    longint unsigned limit, item_size, count, total, item, blk;
    addr = '0;
    err = 1'b0;
    if (size == 0) return;
    c = MinClassLog2;
    while (c < 40 && (64'd1 << c) < size) c++;
    if (c > AddrBits) begin
      err = 1'b1;
      return;
    end
    idx = c - MinClassLog2;
    if (list_head[idx][AddrBits]) begin
      item = list_head[idx][AddrBits-1:0];
      list_head[idx] = next_link[slot_of(item)];
      addr = AddrBits'(item + HeaderBytes);
      return;
    end
    limit = (heap_end > (64'd1 << AddrBits)) ? (64'd1 << AddrBits) : heap_end;
    item_size = HeaderBytes + (64'd1 << c);
    count = (c < CarveLog2) ? (64'd1 << (CarveLog2 - c)) : 64'd1;
    total = item_size * count;
    if (bump > limit || total > limit - bump) begin
      err = 1'b1;
      return;
    end
    item = bump;
    bump = bump + total;
    stored_class[slot_of(item)] = CLASS_W'(c);
    addr = AddrBits'(item + HeaderBytes);
    if (count > 1) begin
      blk = item + item_size;
      list_head[idx] = {1'b1, blk[AddrBits-1:0]};
      for (longint unsigned k = 1; k < count; k++) begin
        blk = item + k * item_size;
        stored_class[slot_of(blk)] = CLASS_W'(c);
        next_link[slot_of(blk)] = (k + 1 < count)
            ? {1'b1, AddrBits'(blk + item_size)} : '0;
      end
    end
  endtask

  task automatic predict_reply(input op_t op, input longint unsigned req,
                               input logic [AddrBits-1:0] ptr, output reply_t r);
    longint unsigned item;
    int c;
    r.addr = '0;
    r.status = 1'b0;
    r.copy = '0;
    if (op == OP_ALLOC) begin
      take_block(req, r.addr, r.status);
    end else if (op == OP_FREE || op == OP_REALLOC) begin
      if (ptr == '0) begin
        if (op == OP_REALLOC) take_block(req, r.addr, r.status);
      end else begin
        item = AddrBits'(ptr - HeaderBytes);
        c = stored_class[slot_of(item)];
        if (op == OP_FREE || req == 0) begin
          if (class_ok(c)) push_block(item, c);
        end else if (class_ok(c) && (64'd1 << c) >= req) begin
          r.addr = ptr;
        end else begin
          take_block(req, r.addr, r.status);
          if (!r.status && class_ok(c)) begin
            r.copy = 16'(64'd1 << c);
            push_block(item, c);
          end
        end
      end
    end
  endtask

  task automatic report(input string field, input longint unsigned got,
                        input longint unsigned want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t fresh;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result item with no request waiting", $realtime);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (out_ch.result_address !== want.addr)
            report("result_address", out_ch.result_address, want.addr);
          if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
          if (out_ch.copy_bytes !== want.copy) report("copy_bytes", out_ch.copy_bytes, want.copy);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) heap_end = cfg_ch.heap_end;
      if (in_ch.valid && in_ch.ready) begin
        predict_reply(op_t'(in_ch.operation), in_ch.request_bytes, in_ch.block_address, fresh);
        replies_due.push_back(fresh);
      end
      outstanding = replies_due.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import p2fla_pkg::*;

  logic clk;
  logic rst_n;

  p2fla_in_if  in_ch ();
  p2fla_out_if out_ch ();
  p2fla_cfg_if cfg_ch ();

  int errors;
  int outstanding;

  // Idle percentages for the sender and the receiver; changed per phase.
  int tx_idle;
  int rx_idle;

  // Handshake flags, registered at the rising edge and read at the falling edge.
  logic in_took;
  logic cfg_took;

  // User addresses currently held by the stimulus; frees and reallocates take from here.
  logic [AddrBits-1:0] live_blocks[$];

  pow2_free_list_allocator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  p2fla_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_took <= in_ch.valid && in_ch.ready;
    cfg_took <= cfg_ch.valid && cfg_ch.ready;
    // Every nonzero address handed back becomes a live block for later frees.
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.result_address != '0)
      live_blocks.push_back(out_ch.result_address);
  end

  // The receiver stalls at random with the current percentage.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
  end

  // Offers one item, idling first with the sender's percentage, and returns once it
  // has been accepted. Called and returning at a falling edge.
  task automatic send(input op_t op, input logic [SIZE_W-1:0] req,
                      input logic [AddrBits-1:0] ptr);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.request_bytes <= req;
    in_ch.block_address <= ptr;
    do @(negedge clk); while (!in_took);
  endtask

  // Waits until every request has been answered, plus a margin for the block to
  // settle back into its idle state.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_heap_end(input logic [HEAP_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.heap_end <= value;
    do @(negedge clk); while (!cfg_took);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Takes a random live block out of the pool; null when the pool is empty.
  function automatic logic [AddrBits-1:0] take_live();
    int i;
    logic [AddrBits-1:0] a;
    if (live_blocks.size() == 0) return '0;
    i = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[i];
    live_blocks.delete(i);
    return a;
  endfunction

  // Mostly small sizes so the free lists get reused; now and then a wide size,
  // a full random 17-bit value or zero.
  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return SIZE_W'($urandom_range(1, 200));
    if (r < 92) return SIZE_W'($urandom_range(1, 4096));
    if (r < 97) return SIZE_W'($urandom);
    return '0;
  endfunction

  task automatic random_items(input int count);
    int r;
    logic [AddrBits-1:0] blk;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send(OP_ALLOC, pick_size(), AddrBits'($urandom));
      end else if (r < 75) begin
        blk = take_live();
        if (blk == '0) send(OP_ALLOC, pick_size(), '0);
        else send(OP_FREE, SIZE_W'($urandom), blk);
      end else if (r < 90) begin
        blk = take_live();
        send(OP_REALLOC, pick_size(), blk);
      end else if (r < 95) begin
        send($urandom_range(0, 1) ? OP_FREE : OP_REALLOC, pick_size(), '0);
      end else begin
        // The unused operation accepts any field values, so it exercises every bit.
        send(OP_NONE, SIZE_W'($urandom), AddrBits'($urandom));
      end
    end
  endtask

  initial begin
    logic [AddrBits-1:0] blk;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.block_address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.heap_end = '0;
    out_ch.ready = 1'b0;
    tx_idle = 37;
    rx_idle = 50;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset heap limit: zero size, smallest classes carving a
    // fresh run, the size limit, a single large block that does not fit, null
    // pointers and the unused operation.
    send(OP_ALLOC, '0, '0);
    send(OP_ALLOC, SIZE_W'(1), '0);
    send(OP_ALLOC, SIZE_W'(8), '0);
    send(OP_ALLOC, SIZE_W'(9), '0);
    send(OP_ALLOC, SIZE_W'(16), '0);
    send(OP_ALLOC, '1, '0);
    send(OP_ALLOC, SIZE_W'(65536), '0);
    send(OP_FREE, SIZE_W'(5), '0);
    send(OP_REALLOC, SIZE_W'(24), '0);
    send(OP_REALLOC, '0, '0);
    send(OP_NONE, '1, '1);
    send(OP_NONE, '0, '0);
    drain();

    // Reallocate cases on blocks that were really handed out: one that still fits,
    // one that has to move, one that shrinks to nothing, one that cannot grow, then
    // a plain free and an allocate of 12 bytes.
    blk = take_live();
    send(OP_REALLOC, SIZE_W'(2), blk);
    blk = take_live();
    send(OP_REALLOC, SIZE_W'(100), blk);
    blk = take_live();
    send(OP_REALLOC, '0, blk);
    blk = take_live();
    send(OP_REALLOC, '1, blk);
    blk = take_live();
    send(OP_FREE, '1, blk);
    send(OP_ALLOC, SIZE_W'(12), '0);
    drain();

    write_heap_end(HEAP_W'(40000));
    random_items(620);
    drain();

    tx_idle = 50;
    rx_idle = 37;
    write_heap_end('0);
    random_items(620);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    write_heap_end('1);
    random_items(310);
    drain();
    write_heap_end(HEAP_W'(HEAP_END_RESET));
    random_items(300);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(200_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- pow2_free_list_allocator_core.f -----
rtl/p2fla_pkg.sv
rtl/p2fla_if.sv
rtl/p2fla_ctrl.sv
rtl/p2fla_dp.sv
rtl/pow2_free_list_allocator_core.sv
tb/p2fla_checker.sv
tb/tb_top.sv
